// File: rtl/hrp_pkg.sv
// Package for the hue rotation pixel block: coefficient table, data widths and shared types.
// No dependencies; used by every module of the block.
package hrp_pkg;

    localparam int ChanW  = 8;
    localparam int CfgW   = 16;
    localparam int CoefW  = 18;
    localparam int Q28W   = 32;
    localparam int ProdW  = ChanW + 1 + CoefW;
    localparam int SumW   = ProdW + 2;
    localparam int FracW  = 14;
    localparam int NCoef  = 9;
    localparam int NChan  = 3;

    localparam logic signed [CfgW-1:0] CosReset = 16'sd16384;
    localparam logic signed [CfgW-1:0] SinReset = 16'sd0;

    typedef enum logic {
        REG_COS_ANGLE = 1'b0,
        REG_SIN_ANGLE = 1'b1
    } cfg_index_t;

    typedef logic signed [CoefW-1:0] coef_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } hrp_occ_t;

    // Base constant, cosine factor and sine factor of each coefficient, all Q.14.
    localparam int KBase [NCoef] = '{3490, 11715, 1180, 3490, 11715, 1180, 3490, 11715, 1180};
    localparam int KCos  [NCoef] = '{12894, -11715, -1180, -3490, 4669, -1180, -3490, -11715,
                                     15204};
    localparam int KSin  [NCoef] = '{-3490, -11715, 15204, 2343, 2294, -4637, -12894, 11715,
                                     1180};

endpackage

// File: rtl/hrp_coef.sv
// Angle registers and the nine hue rotation matrix coefficients derived from them.
// Depends on hrp_pkg.
module hrp_coef
    import hrp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [CfgW-1:0]        cfg_wdata,
    output coef_t                  coef [NCoef]
);

    logic signed [CfgW-1:0] cos_reg, cos_next;
    logic signed [CfgW-1:0] sin_reg, sin_next;
    logic signed [Q28W-1:0] q28 [NCoef];
    logic signed [Q28W-1:0] rnd [NCoef];
    coef_t                  coef_reg  [NCoef];
    coef_t                  coef_next [NCoef];

    always_comb
    begin
        cos_next = cos_reg;
        sin_next = sin_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_COS_ANGLE: cos_next = cfg_wdata;
                REG_SIN_ANGLE: sin_next = cfg_wdata;
                default:       cos_next = cos_reg;
            endcase
        end
    end

    // The coefficients follow the next register values, so that a pixel taken in the
    // same cycle as a write already sees the new angle.
    always_comb
    begin
        for (int i = 0; i < NCoef; i++)
        begin
            q28[i] = Q28W'(KBase[i] * (1 << FracW))
                   + Q28W'(int'(cos_next) * KCos[i])
                   + Q28W'(int'(sin_next) * KSin[i]);
            rnd[i] = (q28[i] + Q28W'(1 << (FracW - 1))) >>> FracW;
            coef_next[i] = rnd[i][CoefW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg <= CosReset;
            sin_reg <= SinReset;
        end
        else
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
    end

    assign coef = coef_reg;

endmodule

// File: rtl/hrp_datapath.sv
// Four-stage pixel pipeline: input register, nine products, channel sums, scale and clamp.
// Depends on hrp_pkg; coefficients come from hrp_coef.
module hrp_datapath
    import hrp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  coef_t             coef [NCoef],
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [ChanW-1:0]  in_chan [NChan],
    input  logic [ChanW-1:0]  in_alpha,
    input  logic              in_last,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ChanW-1:0]  out_chan [NChan],
    output logic [ChanW-1:0]  out_alpha,
    output logic              out_last,
    output hrp_occ_t          occ
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    logic [ChanW-1:0]        px_reg [NChan];
    logic [ChanW-1:0]        a1_reg, a2_reg, a3_reg, a4_reg;
    logic                    l1_reg, l2_reg, l3_reg, l4_reg;
    logic signed [ProdW-1:0] prod_reg  [NCoef];
    logic signed [ProdW-1:0] prod_next [NCoef];
    logic signed [SumW-1:0]  sum_reg   [NChan];
    logic signed [SumW-1:0]  sum_next  [NChan];
    logic signed [SumW-FracW-1:0] scaled [NChan];
    logic [ChanW-1:0]        res_reg   [NChan];
    logic [ChanW-1:0]        res_next  [NChan];
    logic signed [ChanW:0]   px_s      [NChan];

    // A stage moves on when the one after it is empty or moving itself.
    assign en4 = !v4_reg || out_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        for (int k = 0; k < NChan; k++)
        begin
            px_s[k] = $signed({1'b0, px_reg[k]});
        end
        for (int i = 0; i < NCoef; i++)
        begin
            prod_next[i] = px_s[i % NChan] * coef[i];
        end
        for (int c = 0; c < NChan; c++)
        begin
            sum_next[c] = SumW'(prod_reg[c*NChan]) + SumW'(prod_reg[c*NChan+1])
                        + SumW'(prod_reg[c*NChan+2]);
            scaled[c] = sum_reg[c][SumW-1:FracW];
            if (scaled[c] < 0)
                res_next[c] = '0;
            else if (scaled[c] > $signed((SumW-FracW)'(255)))
                res_next[c] = '1;
            else
                res_next[c] = scaled[c][ChanW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            px_reg <= in_chan;
            a1_reg <= in_alpha;
            l1_reg <= in_last;
        end
        if (en2)
        begin
            prod_reg <= prod_next;
            a2_reg   <= a1_reg;
            l2_reg   <= l1_reg;
        end
        if (en3)
        begin
            sum_reg <= sum_next;
            a3_reg  <= a2_reg;
            l3_reg  <= l2_reg;
        end
        if (en4)
        begin
            res_reg <= res_next;
            a4_reg  <= a3_reg;
            l4_reg  <= l3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_chan  = res_reg;
    assign out_alpha = a4_reg;
    assign out_last  = l4_reg;
    assign occ       = '{s1: v1_reg, s2: v2_reg, s3: v3_reg, s4: v4_reg};

endmodule

// File: rtl/hue_rotate_pixel.sv
// Top level of the hue rotation pixel block: stream ports, configuration port, assertions.
// Depends on hrp_pkg, hrp_coef and hrp_datapath.
//
// The block takes one RGB pixel per clock while the output is not stalled and returns it
// hue-rotated after its four register stages (input, nine products, channel sums, scale
// and clamp); a stalled output holds its transaction while empty stages upstream
// keep filling. Each channel is the sum of three products with coefficients formed from
// the cosine and sine registers (signed Q1.14), scaled down by 2^14 with floor and
// saturated to 0..255. Alpha and the end-of-frame mark on tlast pass through unchanged.
// A register write takes effect for the pixel accepted in the same cycle and after it.
module hue_rotate_pixel
    import hrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // red_in, green_in, blue_in, alpha_in
    input  logic        s_tlast,   // frame_end_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // red_out, green_out, blue_out, alpha_out
    output logic        m_tlast    // frame_end_out
);

    coef_t            coef     [NCoef];
    logic [ChanW-1:0] in_chan  [NChan];
    logic [ChanW-1:0] out_chan [NChan];
    logic [ChanW-1:0] out_alpha;
    hrp_occ_t         occ;

    assign in_chan[0] = s_tdata[7:0];
    assign in_chan[1] = s_tdata[15:8];
    assign in_chan[2] = s_tdata[23:16];

    hrp_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .coef      (coef)
    );

    hrp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_chan   (in_chan),
        .in_alpha  (s_tdata[31:24]),
        .in_last   (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_chan  (out_chan),
        .out_alpha (out_alpha),
        .out_last  (m_tlast),
        .occ       (occ)
    );

    assign m_tdata = {out_alpha, out_chan[2], out_chan[1], out_chan[0]};

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("Input stalled although the output stage can move.");

    a_ready_means_room: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !(occ.s1 && occ.s2 && occ.s3 && occ.s4 && !m_tready))
        else $error("Input ready while every stage is full and the output is stalled.");

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> occ.s1)
        else $error("Accepted transaction did not reach the first stage.");

endmodule

// File: tb/tb_hue_rotate_pixel.sv
// Testbench for hue_rotate_pixel: streams pixels through the block under several angle settings
// and checks every rotated pixel against a predicted copy held in a small scoreboard class.
// Depends on hrp_pkg and the hue_rotate_pixel RTL.

typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       frame_end;
} pixel_t;

class hue_rotation_board;
    int      base_k[9];
    int      cos_k[9];
    int      sin_k[9];
    shortint cos_q14;
    shortint sin_q14;
    pixel_t  expected_pixels[$];
    int      mismatch_count;

    function new();
        base_k = '{3490, 11715, 1180, 3490, 11715, 1180, 3490, 11715, 1180};
        cos_k  = '{12894, -11715, -1180, -3490, 4669, -1180, -3490, -11715, 15204};
        sin_k  = '{-3490, -11715, 15204, 2343, 2294, -4637, -12894, 11715, 1180};
        cos_q14 = 16384;
        sin_q14 = 0;
        mismatch_count = 0;
    endfunction

    function void set_angle(hrp_pkg::cfg_index_t idx, shortint value);
        if (idx == hrp_pkg::REG_COS_ANGLE)
            cos_q14 = value;
        else
            sin_q14 = value;
    endfunction

    function pixel_t rotated(pixel_t p);
        longint coef[9];
        longint acc;
        longint level[3];
        pixel_t r;
        for (int i = 0; i < 9; i++)
        begin
            coef[i] = (longint'(base_k[i]) * 16384 + longint'(cos_q14) * cos_k[i]
                       + longint'(sin_q14) * sin_k[i] + 8192) >>> 14;
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            acc = longint'(p.red) * coef[ch*3] + longint'(p.green) * coef[ch*3+1]
                  + longint'(p.blue) * coef[ch*3+2];
            level[ch] = acc >>> 14;
            if (level[ch] < 0)
                level[ch] = 0;
            else if (level[ch] > 255)
                level[ch] = 255;
        end
        r.red       = 8'(level[0]);
        r.green     = 8'(level[1]);
        r.blue      = 8'(level[2]);
        r.alpha     = p.alpha;
        r.frame_end = p.frame_end;
        return r;
    endfunction

    function void note_pixel(pixel_t p);
        expected_pixels.push_back(rotated(p));
    endfunction

    function void report(string what, int want, int got);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void check_pixel(pixel_t got);
        pixel_t want;
        if (expected_pixels.size() == 0)
        begin
            mismatch_count++;
            $display("%0t: unexpected output transaction, expected none, got %0d %0d %0d %0d %0d",
                     $time, got.red, got.green, got.blue, got.alpha, got.frame_end);
            return;
        end
        want = expected_pixels.pop_front();
        if (got.red !== want.red)
            report("red", want.red, got.red);
        if (got.green !== want.green)
            report("green", want.green, got.green);
        if (got.blue !== want.blue)
            report("blue", want.blue, got.blue);
        if (got.alpha !== want.alpha)
            report("alpha", want.alpha, got.alpha);
        if (got.frame_end !== want.frame_end)
            report("frame_end", want.frame_end, got.frame_end);
    endfunction

    function int pending();
        return expected_pixels.size();
    endfunction
endclass

module tb_hue_rotate_pixel;
    import hrp_pkg::*;

    localparam int PIPE_DEPTH  = 4;
    localparam int STALL_LIMIT = 1000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 180;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // red, green, blue, alpha
    logic        s_tlast;   // frame end
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // red, green, blue, alpha
    logic        m_tlast;   // frame end

    hue_rotation_board board;
    logic in_taken = 1'b0;
    logic feed_idle;
    logic drain_idle;
    int   quiet_cycles = 0;

    hue_rotate_pixel DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic int idle_length(logic enabled);
        int pick;
        pick = $urandom_range(0, 99);
        if (!enabled || pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] channel_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 8'd0;
        if (pick == 1)
            return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_pixel(pixel_t p);
        int gap;
        gap = idle_length(feed_idle);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {p.alpha, p.blue, p.green, p.red};
        s_tlast  = p.frame_end;
        do
            @(negedge clk);
        while (!in_taken);
    endtask

    task automatic drain_pipeline();
        s_tvalid = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 2) @(negedge clk);
    endtask

    task automatic write_angles(shortint cos_value, shortint sin_value);
        cfg_we    = 1'b1;
        cfg_index = REG_COS_ANGLE;
        cfg_wdata = cos_value;
        board.set_angle(REG_COS_ANGLE, cos_value);
        @(negedge clk);
        cfg_index = REG_SIN_ANGLE;
        cfg_wdata = sin_value;
        board.set_angle(REG_SIN_ANGLE, sin_value);
        @(negedge clk);
        cfg_we = 1'b0;
        @(negedge clk);
    endtask

    task automatic send_directed();
        pixel_t p;
        logic [39:0] corner[8];
        corner = '{{8'd0,   8'd0,   8'd0,   8'h00, 8'd0},
                   {8'd255, 8'd255, 8'd255, 8'hff, 8'd1},
                   {8'd255, 8'd0,   8'd0,   8'h5a, 8'd0},
                   {8'd0,   8'd255, 8'd0,   8'ha5, 8'd0},
                   {8'd0,   8'd0,   8'd255, 8'h0f, 8'd1},
                   {8'd128, 8'd64,  8'd32,  8'hf0, 8'd0},
                   {8'd1,   8'd2,   8'd3,   8'h00, 8'd0},
                   {8'd254, 8'd1,   8'd127, 8'hff, 8'd1}};
        foreach (corner[i])
        begin
            {p.red, p.green, p.blue, p.alpha} = corner[i][39:8];
            p.frame_end = corner[i][0];
            send_pixel(p);
        end
    endtask

    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t sent;
        in_taken = s_tvalid && s_tready;
        if (in_taken)
        begin
            {sent.alpha, sent.blue, sent.green, sent.red} = s_tdata;
            sent.frame_end = s_tlast;
            board.note_pixel(sent);
        end
        if (m_tvalid && m_tready)
        begin
            {got.alpha, got.blue, got.green, got.red} = m_tdata;
            got.frame_end = m_tlast;
            board.check_pixel(got);
        end
        if (in_taken || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int run;
        int gap;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!drain_idle)
            begin
                m_tready = 1'b1;
            end
            else
            begin
                run = $urandom_range(1, 12);
                m_tready = 1'b1;
                repeat (run - 1) @(negedge clk);
                gap = idle_length(1'b1);
                if (gap > 0)
                begin
                    @(negedge clk);
                    m_tready = 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
        end
    end

    initial
    begin
        shortint cos_list[PHASES];
        shortint sin_list[PHASES];
        pixel_t  p;
        int      spread;
        board        = new();
        feed_idle    = 1'b1;
        drain_idle   = 1'b1;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_COS_ANGLE;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        cos_list = '{-16384, 0, 0, 32767, -32768, 11585, 0, 0, 0, 16384};
        sin_list = '{0, 16384, -16384, -32768, 32767, 11585, 0, 0, 0, 0};
        for (int k = 6; k < 8; k++)
        begin
            spread = $urandom_range(0, 32768);
            cos_list[k] = shortint'(spread - 16384);
            spread = $urandom_range(0, 32768);
            sin_list[k] = shortint'(spread - 16384);
        end
        cos_list[8] = shortint'($urandom);
        sin_list[8] = shortint'($urandom);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_directed();
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_pipeline();
            write_angles(cos_list[ph], sin_list[ph]);
            feed_idle  = (ph % 3) != 1;
            drain_idle = (ph % 4) != 2;
            if (ph == 0)
                send_directed();
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                p.red       = channel_value();
                p.green     = channel_value();
                p.blue      = channel_value();
                p.alpha     = 8'($urandom_range(0, 255));
                p.frame_end = ($urandom_range(0, 15) == 0);
                send_pixel(p);
            end
        end
        drain_pipeline();
        repeat (PIPE_DEPTH * 2) @(negedge clk);
        if (board.mismatch_count == 0 && board.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// File: files.f
rtl/hrp_pkg.sv
rtl/hrp_coef.sv
rtl/hrp_datapath.sv
rtl/hue_rotate_pixel.sv
tb/tb_hue_rotate_pixel.sv
